@@ sv/bilinear_height_sampler_defines.svh @@
// Assertion macros for the bilinear height sampler.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef BILINEAR_HEIGHT_SAMPLER_DEFINES_SVH
`define BILINEAR_HEIGHT_SAMPLER_DEFINES_SVH
`ifndef SYNTHESIS
`define BHS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define BHS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BHS_ASSERT_IMP(lbl, ante, cons, msg)
`define BHS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/bhs_pkg.sv @@
`default_nettype none
package bhs_pkg;

  // Fixed field widths
  localparam int HEIGHT_BITS = 16;
  localparam int INDEX_BITS  = 12;
  localparam int WORLD_BITS  = 24;
  localparam int CFG_BITS    = 16;
  // Fraction bits of world (Q16.8) plus those of inv_spacing (Q8.8)
  localparam int PROD_FRAC   = 16;

  localparam logic [CFG_BITS-1:0] INV_SPACING_RESET = 16'd256;

  // Request codes
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef struct packed {
    logic                          req_type;
    logic [INDEX_BITS-1:0]         node_index;
    logic signed [HEIGHT_BITS-1:0] height_value;
    logic signed [WORLD_BITS-1:0]  world_x;
    logic signed [WORLD_BITS-1:0]  world_z;
  } in_word_t;

  typedef struct packed {
    logic signed [HEIGHT_BITS-1:0] height_out;
    logic                          edge_clamped;
  } out_word_t;

endpackage
`default_nettype wire

@@ sv/bhs_ram.sv @@
`default_nettype none
module bhs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold while disabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ sv/bilinear_height_sampler.sv @@
// Bilinear height sampler.
// Input channel (in_valid / in_stall / in_data) carries one word per item:
// a write word stores height_value at node_index and gives no result, a
// sample word gives one result word on the output channel (out_valid /
// out_stall / out_data) with the blended height and an edge-clamp flag.
// The cfg channel (cfg_valid / cfg_ready / cfg_data) loads inv_spacing;
// cfg_ready is always high and the value should change only when idle.
// Pipeline: input multiply, grid coordinate and clamp, four replicated
// height RAMs read in parallel, row blend, column blend, round/saturate
// into the output register. A sample word passes these stages in order;
// one word is taken every cycle while in_stall is low, set by the single
// read port of each RAM copy, which every item uses once.
// Each stage advances when the stage after it is empty or advancing, so a
// stalled receiver fills the bubbles first and in_stall rises only when
// the first stage holds a word that cannot move.
// Reset (rst_n low at a clock edge) empties the pipeline and sets
// inv_spacing to 256; stored heights are not cleared and must be written
// before they are sampled.
`default_nettype none
`include "bilinear_height_sampler_defines.svh"
module bilinear_height_sampler #(
  parameter int GRID_SIDE = 64,
  parameter int FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bhs_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bhs_pkg::out_word_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bhs_pkg::CFG_BITS-1:0]  cfg_data
);
  import bhs_pkg::*;

  localparam int NODE_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int AW = $clog2(NODE_COUNT);
  localparam int CW = $clog2(GRID_SIDE);
  localparam int PW = WORLD_BITS + CFG_BITS + 1;
  localparam int GW = PW + 1;
  localparam int SH = PROD_FRAC - FRAC_BITS;
  localparam int HB = HEIGHT_BITS;
  localparam int WW = FRAC_BITS + 1;
  localparam int RW = HB + WW + 1;
  localparam int SW = RW + WW + 1;
  localparam int OW = SW - 2 * FRAC_BITS;

  localparam logic signed [GW-1:0] OFFSET  = GW'(GRID_SIDE) <<< (FRAC_BITS - 1);
  localparam logic signed [GW-1:0] SIDE_M1 = GW'(GRID_SIDE - 1);
  localparam logic signed [GW-1:0] NEG_ONE = '1;
  localparam logic [CW-1:0]        EDGE_HI = CW'(GRID_SIDE - 1);
  localparam logic [WW-1:0]        S_FULL  = WW'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] HALF    = SW'(1) <<< (2 * FRAC_BITS - 1);
  localparam logic signed [OW-1:0] HMAX    = OW'((2 ** (HB - 1)) - 1);
  localparam logic signed [OW-1:0] HMIN    = -HMAX - OW'(1);

  // Stage advance chain
  logic free1, free2, free3, free4, free5, free6;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  assign free6 = !v6_r || !out_stall;
  assign free5 = !v5_r || free6;
  assign free4 = !v4_r || free5;
  assign free3 = !v3_r || free4;
  assign free2 = !v2_r || free3;
  assign free1 = !v1_r || free2;
  assign in_stall = !free1;

  // Configuration register
  logic [CFG_BITS-1:0] inv_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= INV_SPACING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      inv_r <= cfg_data;
    end
  end

  // Stage 1: scale world coordinates
  logic                  s1_smp_r;
  logic [INDEX_BITS-1:0] s1_idx_r;
  logic [HB-1:0]         s1_hgt_r;
  logic signed [PW-1:0]  s1_p_r [2];
  logic signed [PW-1:0]  p_nxt [2];

  assign p_nxt[0] = in_data.world_x * $signed({1'b0, inv_r});
  assign p_nxt[1] = in_data.world_z * $signed({1'b0, inv_r});

  always_ff @(posedge clk) begin
    if (free1) begin
      s1_smp_r <= (in_data.req_type == REQ_SAMPLE);
      s1_idx_r <= in_data.node_index;
      s1_hgt_r <= in_data.height_value;
      s1_p_r   <= p_nxt;
    end
  end

  // Stage 2: grid coordinate, clamp, corner addresses
  logic signed [GW-1:0] g [2];
  logic signed [GW-1:0] n [2];
  logic [FRAC_BITS-1:0] t [2];
  logic [CW-1:0]        na [2];
  logic [CW-1:0]        nb [2];
  logic [1:0]           clamp_ax;
  logic [AW-1:0]        raddr_nxt [4];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      g[a] = (s1_p_r[a] >>> SH) + OFFSET;
      n[a] = g[a] >>> FRAC_BITS;
      t[a] = g[a][FRAC_BITS-1:0];
      clamp_ax[a] = n[a][GW-1] || (n[a] >= SIDE_M1);
      if (n[a][GW-1]) begin
        na[a] = '0;
      end else if (n[a] > SIDE_M1) begin
        na[a] = EDGE_HI;
      end else begin
        na[a] = n[a][CW-1:0];
      end
      if (n[a] < NEG_ONE) begin
        nb[a] = '0;
      end else if (n[a] >= SIDE_M1) begin
        nb[a] = EDGE_HI;
      end else begin
        nb[a] = n[a][CW-1:0] + CW'(1);
      end
    end
    for (int c = 0; c < 4; c++) begin
      raddr_nxt[c] = AW'((c[1] ? nb[1] : na[1]) * GRID_SIDE + (c[0] ? nb[0] : na[0]));
    end
  end

  logic                 s2_smp_r;
  logic                 s2_wok_r;
  logic [AW-1:0]        s2_waddr_r;
  logic [HB-1:0]        s2_wdata_r;
  logic [AW-1:0]        s2_raddr_r [4];
  logic [FRAC_BITS-1:0] s2_tx_r, s2_tz_r;
  logic                 s2_clamp_r;

  always_ff @(posedge clk) begin
    if (free2) begin
      s2_smp_r   <= s1_smp_r;
      s2_wok_r   <= (32'(s1_idx_r) < NODE_COUNT);
      s2_waddr_r <= AW'(s1_idx_r);
      s2_wdata_r <= s1_hgt_r;
      s2_raddr_r <= raddr_nxt;
      s2_tx_r    <= t[0];
      s2_tz_r    <= t[1];
      s2_clamp_r <= |clamp_ax;
    end
  end

  // Stage 3: height store, one copy per corner
  logic          ram_we;
  logic [HB-1:0] rd_raw [4];

  assign ram_we = free3 && v2_r && !s2_smp_r && s2_wok_r;

  for (genvar c = 0; c < 4; c++) begin : g_bank
    bhs_ram #(
      .WIDTH (HB),
      .DEPTH (NODE_COUNT)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (s2_waddr_r),
      .wdata (s2_wdata_r),
      .re    (free3),
      .raddr (s2_raddr_r[c]),
      .rdata (rd_raw[c])
    );
  end

  logic [FRAC_BITS-1:0] s3_tx_r, s3_tz_r;
  logic                 s3_clamp_r;

  always_ff @(posedge clk) begin
    if (free3) begin
      s3_tx_r    <= s2_tx_r;
      s3_tz_r    <= s2_tz_r;
      s3_clamp_r <= s2_clamp_r;
    end
  end

  // Stage 4: blend along x
  logic [WW-1:0]        wx0, wx1;
  logic signed [RW-1:0] top_nxt, bot_nxt;
  logic signed [RW-1:0] s4_top_r, s4_bot_r;
  logic [FRAC_BITS-1:0] s4_tz_r;
  logic                 s4_clamp_r;

  assign wx1 = {1'b0, s3_tx_r};
  assign wx0 = S_FULL - wx1;
  assign top_nxt = $signed(rd_raw[0]) * $signed({1'b0, wx0})
                 + $signed(rd_raw[1]) * $signed({1'b0, wx1});
  assign bot_nxt = $signed(rd_raw[2]) * $signed({1'b0, wx0})
                 + $signed(rd_raw[3]) * $signed({1'b0, wx1});

  always_ff @(posedge clk) begin
    if (free4) begin
      s4_top_r   <= top_nxt;
      s4_bot_r   <= bot_nxt;
      s4_tz_r    <= s3_tz_r;
      s4_clamp_r <= s3_clamp_r;
    end
  end

  // Stage 5: blend along z
  logic [WW-1:0]        wz0, wz1;
  logic signed [SW-1:0] sum_nxt;
  logic signed [SW-1:0] s5_sum_r;
  logic                 s5_clamp_r;

  assign wz1 = {1'b0, s4_tz_r};
  assign wz0 = S_FULL - wz1;
  assign sum_nxt = s4_top_r * $signed({1'b0, wz0}) + s4_bot_r * $signed({1'b0, wz1});

  always_ff @(posedge clk) begin
    if (free5) begin
      s5_sum_r   <= sum_nxt;
      s5_clamp_r <= s4_clamp_r;
    end
  end

  // Stage 6: round half up, saturate, hold for the receiver
  logic signed [SW-1:0] rnd;
  logic signed [OW-1:0] hq;
  logic signed [HB-1:0] hsat;
  out_word_t            out_r;

  assign rnd = s5_sum_r + HALF;
  assign hq  = OW'(rnd >>> (2 * FRAC_BITS));

  always_comb begin
    if (hq > HMAX) begin
      hsat = HB'(HMAX);
    end else if (hq < HMIN) begin
      hsat = HB'(HMIN);
    end else begin
      hsat = hq[HB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (free6) begin
      out_r.height_out   <= hsat;
      out_r.edge_clamped <= s5_clamp_r;
    end
  end

  assign out_data  = out_r;
  assign out_valid = v6_r;

  // Valid bits; write words drop out at the RAM stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (free1) v1_r <= in_valid;
      if (free2) v2_r <= v1_r;
      if (free3) v3_r <= v2_r && s2_smp_r;
      if (free4) v4_r <= v3_r;
      if (free5) v5_r <= v4_r;
      if (free6) v6_r <= v5_r;
    end
  end

  // Checks
  `BHS_ASSERT_IMP(a_stall_needs_word, in_stall, v1_r, "input stalled with empty first stage")
  `BHS_ASSERT_NXT(a_write_no_result, ram_we, !v3_r, "stored write word went on as a sample")
  `BHS_ASSERT_IMP(a_out_from_stage5, $rose(out_valid), $past(v5_r), "result without a source")

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bhs_pkg::*;

  localparam int GRID_SIDE = 64;
  localparam int FRAC_BITS = 8;
  localparam int NODES     = GRID_SIDE * GRID_SIDE;
  localparam longint FRAC_ONE = 1 << FRAC_BITS;
  localparam int DRAIN_CYCLES = 12;
  localparam int TAIL_CYCLES  = 20;

  typedef enum int {ROW_WRITE, ROW_SAMPLE, ROW_SPACING} row_kind_e;

  typedef struct {
    row_kind_e kind;
    int        idx;
    int        val;     // height for writes, inv_spacing for spacing rows
    int        wx;
    int        wz;
    bit        typed;
    out_word_t want;
  } plan_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_word_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_word_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_data;

  // Shadow state of the sampler
  logic signed [HEIGHT_BITS-1:0] node_height [NODES];
  bit                            node_written[NODES];
  logic [CFG_BITS-1:0]           spacing;

  out_word_t height_q[$];
  int        fail_count;
  bit        in_calm;
  bit        out_calm;
  plan_row_t plan[$];

  bilinear_height_sampler #(
    .GRID_SIDE(GRID_SIDE),
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Map one world axis to a floor node and a fraction at the current spacing
  function automatic void split_coord(input logic signed [WORLD_BITS-1:0] w,
                                      output longint node, output longint frac);
    longint p, g;
    p = longint'(w) * longint'(spacing);
    g = (p >>> (PROD_FRAC - FRAC_BITS)) + GRID_SIDE * (FRAC_ONE / 2);
    node = g >>> FRAC_BITS;
    frac = g & (FRAC_ONE - 1);
  endfunction

  function automatic int clamp_axis(input longint c, inout bit hit);
    if (c < 0) begin
      hit = 1'b1;
      return 0;
    end
    if (c > GRID_SIDE - 1) begin
      hit = 1'b1;
      return GRID_SIDE - 1;
    end
    return int'(c);
  endfunction

  // Blend the four corner heights, round half up and saturate
  function automatic out_word_t predict_height(input logic signed [WORLD_BITS-1:0] wx,
                                               input logic signed [WORLD_BITS-1:0] wz);
    longint nx, fx, nz, fz, top, bot, sum, h;
    int xa, xb, za, zb;
    bit hit;
    out_word_t r;
    hit = 1'b0;
    split_coord(wx, nx, fx);
    split_coord(wz, nz, fz);
    xa = clamp_axis(nx, hit);
    xb = clamp_axis(nx + 1, hit);
    za = clamp_axis(nz, hit);
    zb = clamp_axis(nz + 1, hit);
    top = longint'(node_height[za*GRID_SIDE+xa]) * (FRAC_ONE - fx)
        + longint'(node_height[za*GRID_SIDE+xb]) * fx;
    bot = longint'(node_height[zb*GRID_SIDE+xa]) * (FRAC_ONE - fx)
        + longint'(node_height[zb*GRID_SIDE+xb]) * fx;
    sum = top * (FRAC_ONE - fz) + bot * fz;
    h = (sum + (FRAC_ONE * FRAC_ONE / 2)) >>> (2 * FRAC_BITS);
    if (h > 32767) h = 32767;
    if (h < -32768) h = -32768;
    r.height_out   = h[HEIGHT_BITS-1:0];
    r.edge_clamped = hit;
    return r;
  endfunction

  function automatic in_word_t write_word(input logic [INDEX_BITS-1:0] idx,
                                          input logic [HEIGHT_BITS-1:0] hv);
    in_word_t w;
    w.req_type     = REQ_WRITE;
    w.node_index   = idx;
    w.height_value = hv;
    w.world_x      = WORLD_BITS'($urandom());
    w.world_z      = WORLD_BITS'($urandom());
    return w;
  endfunction

  function automatic in_word_t sample_word(input logic signed [WORLD_BITS-1:0] wx,
                                           input logic signed [WORLD_BITS-1:0] wz);
    in_word_t w;
    w.req_type     = REQ_SAMPLE;
    w.node_index   = INDEX_BITS'($urandom());
    w.height_value = HEIGHT_BITS'($urandom());
    w.world_x      = wx;
    w.world_z      = wz;
    return w;
  endfunction

  function automatic plan_row_t row(input row_kind_e kind, input int idx, input int val,
                                    input int wx, input int wz, input bit typed,
                                    input int eh, input bit ec);
    plan_row_t r;
    r.kind  = kind;
    r.idx   = idx;
    r.val   = val;
    r.wx    = wx;
    r.wz    = wz;
    r.typed = typed;
    r.want.height_out   = eh[HEIGHT_BITS-1:0];
    r.want.edge_clamped = ec;
    return r;
  endfunction

  // Append one row to the directed plan
  task automatic add_row(input plan_row_t r);
    plan = {plan, r};
  endtask

  // Mostly short gaps, a few long ones; none in a calm stretch
  function automatic int pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  // World coordinate: mostly inside the grid, some near the edges, some anywhere
  function automatic logic signed [WORLD_BITS-1:0] pick_world();
    longint g, w;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15 || spacing == 0) begin
      w = longint'($urandom());
      return w[WORLD_BITS-1:0];
    end
    if (r < 35)
      g = ($urandom_range(0, 1) ? (GRID_SIDE - 1) * FRAC_ONE : 0)
        + longint'($urandom_range(0, 512)) - 256;
    else
      g = longint'($urandom_range(0, (GRID_SIDE + 2) * 256)) - 256;
    w = ((g - GRID_SIDE * (FRAC_ONE / 2)) * 256) / longint'(spacing);
    if (w > 8388607) w = 8388607;
    if (w < -8388608) w = -8388608;
    return w[WORLD_BITS-1:0];
  endfunction

  // Send one word, hold it until accepted, then advance the shadow state
  task automatic push_word(input in_word_t w, input bit typed, input out_word_t want);
    int gap;
    gap = pick_gap(in_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (w.req_type == REQ_WRITE) begin
      node_height[w.node_index]  = w.height_value;
      node_written[w.node_index] = 1'b1;
    end else begin
      height_q = {height_q, (typed ? want : predict_height(w.world_x, w.world_z))};
    end
  endtask

  // Write any corner not yet stored, then issue the sample
  task automatic sample_at(input logic signed [WORLD_BITS-1:0] wx,
                           input logic signed [WORLD_BITS-1:0] wz,
                           input bit typed, input out_word_t want);
    longint nx, fx, nz, fz;
    int c, r, idx;
    bit hit;
    hit = 1'b0;
    split_coord(wx, nx, fx);
    split_coord(wz, nz, fz);
    for (int dz = 0; dz < 2; dz++) begin
      for (int dx = 0; dx < 2; dx++) begin
        c = clamp_axis(nx + dx, hit);
        r = clamp_axis(nz + dz, hit);
        idx = r * GRID_SIDE + c;
        if (!node_written[idx])
          push_word(write_word(idx[INDEX_BITS-1:0], HEIGHT_BITS'($urandom())), 1'b0, '0);
      end
    end
    push_word(sample_word(wx, wz), typed, want);
  endtask

  // Drain the pipeline, then load inv_spacing
  task automatic set_spacing(input logic [CFG_BITS-1:0] v);
    @(negedge clk);
    in_valid = 1'b0;
    while (height_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    spacing = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver stalls
  initial begin : drive_out_stall
    int n;
    out_stall = 1'b0;
    forever begin
      n = pick_gap(out_calm);
      if (n > 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall = 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (height_q.size() == 0) begin
        $display("%0t: unexpected result height_out %0d edge_clamped %0b",
                 $time, out_data.height_out, out_data.edge_clamped);
        fail_count++;
      end else begin
        want = height_q.pop_front();
        if (out_data.height_out !== want.height_out) begin
          $display("%0t: height_out expected %0d got %0d",
                   $time, want.height_out, out_data.height_out);
          fail_count++;
        end
        if (out_data.edge_clamped !== want.edge_clamped) begin
          $display("%0t: edge_clamped expected %0b got %0b",
                   $time, want.edge_clamped, out_data.edge_clamped);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [CFG_BITS-1:0] v;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    fail_count = 0;
    in_calm    = 1'b0;
    out_calm   = 1'b0;
    spacing    = INV_SPACING_RESET;
    foreach (node_written[i]) begin
      node_written[i] = 1'b0;
      node_height[i]  = '0;
    end

    // Directed part: centre cell, rounding, far extremes, grid borders, spacing extremes
    add_row(row(ROW_WRITE, 2080, 32767, 0, 0, 0, 0, 0));
    add_row(row(ROW_WRITE, 2081, -32768, 0, 0, 0, 0, 0));
    add_row(row(ROW_WRITE, 2144, 4660, 0, 0, 0, 0, 0));
    add_row(row(ROW_WRITE, 2145, 0, 0, 0, 0, 0, 0));
    add_row(row(ROW_SAMPLE, 0, 0, 0, 0, 1, 32767, 0));
    add_row(row(ROW_SAMPLE, 0, 0, 128, 0, 1, 0, 0));
    add_row(row(ROW_SAMPLE, 0, 0, 255, 255, 0, 0, 0));
    add_row(row(ROW_WRITE, 4095, 256, 0, 0, 0, 0, 0));
    add_row(row(ROW_WRITE, 0, -256, 0, 0, 0, 0, 0));
    add_row(row(ROW_SAMPLE, 0, 0, 8388607, 8388607, 1, 256, 1));
    add_row(row(ROW_SAMPLE, 0, 0, -8388608, -8388608, 1, -256, 1));
    add_row(row(ROW_SAMPLE, 0, 0, 8388607, -8388608, 0, 0, 0));
    add_row(row(ROW_SAMPLE, 0, 0, 7936, 0, 0, 0, 0));
    add_row(row(ROW_SAMPLE, 0, 0, -8192, -8192, 0, 0, 0));
    add_row(row(ROW_SAMPLE, 0, 0, -8193, 0, 0, 0, 0));
    add_row(row(ROW_SPACING, 0, 0, 0, 0, 0, 0, 0));
    add_row(row(ROW_SAMPLE, 0, 0, 8388607, -8388608, 1, 32767, 0));
    add_row(row(ROW_SPACING, 0, 65535, 0, 0, 0, 0, 0));
    add_row(row(ROW_SAMPLE, 0, 0, 1, 1, 0, 0, 0));
    add_row(row(ROW_SAMPLE, 0, 0, -8388608, 1, 0, 0, 0));
    add_row(row(ROW_SPACING, 0, 1, 0, 0, 0, 0, 0));
    add_row(row(ROW_SAMPLE, 0, 0, -1, -1, 0, 0, 0));
    add_row(row(ROW_SPACING, 0, 256, 0, 0, 0, 0, 0));
    add_row(row(ROW_SAMPLE, 0, 0, 64, 192, 0, 0, 0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_WRITE: begin
          push_word(write_word(plan[i].idx[INDEX_BITS-1:0], plan[i].val[HEIGHT_BITS-1:0]),
                    1'b0, '0);
        end
        ROW_SAMPLE: begin
          sample_at(plan[i].wx[WORLD_BITS-1:0], plan[i].wz[WORLD_BITS-1:0],
                    plan[i].typed, plan[i].want);
        end
        default: begin
          set_spacing(plan[i].val[CFG_BITS-1:0]);
        end
      endcase
    end

    // Random part: one spacing per phase, random writes and samples with their corners filled in
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: v = 16'hFFFF;
        1: v = 16'd1;
        2: v = 16'd0;
        3: v = 16'd256;
        4: v = 16'd384;
        5: v = CFG_BITS'($urandom_range(2, 255));
        default: v = CFG_BITS'($urandom_range(1, 65535));
      endcase
      set_spacing(v);
      for (int i = 0; i < 40; i++) begin
        if (i % 20 == 0) begin
          in_calm  = ($urandom_range(0, 3) == 0);
          out_calm = ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 3) == 0)
          push_word(write_word(INDEX_BITS'($urandom_range(0, NODES - 1)),
                               HEIGHT_BITS'($urandom())), 1'b0, '0);
        else
          sample_at(pick_world(), pick_world(), 1'b0, '0);
      end
    end

    // Drop valid, wait out the pipeline
    @(negedge clk);
    in_valid = 1'b0;
    while (height_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
`default_nettype wire
